// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hsi2rgb_pkg.sv =====
`default_nettype none

package hsi2rgb_pkg;

	localparam int HUE_W    = 16;
	localparam int CH_W     = 8;
	localparam int H_W      = 11;          // offset inside a sector, 0..1199
	localparam int HUE_PERIOD  = 3600;
	localparam int SECTOR_SPAN = 1200;

	// hue / 3600 by reciprocal: floor(2^25 / 3600), result low by at most one
	localparam int HUE_RECIP       = 9320;
	localparam int HUE_RECIP_W     = 14;
	localparam int HUE_RECIP_SHIFT = 25;

	// v / 765 by reciprocal: floor(2^28 / 765), result low by at most one
	localparam int CHAN_DIV        = 765;
	localparam int DIV_RECIP       = 350896;
	localparam int DIV_RECIP_W     = 19;
	localparam int DIV_RECIP_SHIFT = 28;
	localparam int DIV_IN_W        = 18;
	localparam int DIV_PROD_W      = DIV_IN_W + DIV_RECIP_W;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// ratio table generation, Q30 arithmetic
	localparam logic [63:0] ONE_Q30   = 64'd1073741824;
	localparam logic [63:0] PI_Q30    = 64'd3373259426;
	localparam logic [63:0] SQRT3_Q30 = 64'd1859775393;
	localparam int TAYLOR_TERMS = 10;

	typedef enum logic [1:0] {
		SEC_RED_LEAD   = 2'd0,
		SEC_GREEN_LEAD = 2'd1,
		SEC_BLUE_LEAD  = 2'd2
	} sector_t;

	typedef struct packed {
		sector_t           sector;
		logic [H_W-1:0]    h;
		logic [CH_W-1:0]   sat;
		logic [CH_W-1:0]   inten;
	} item_t;

	// shift-subtract unsigned divide, table build only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] rem;
		logic [63:0] quo;
		int          i;
		rem = '0;
		quo = '0;
		for (i = 63; i >= 0; i--) begin
			rem = {rem[63:0], n[i]};
			if (rem >= {1'b0, d}) begin
				rem    = rem - {1'b0, d};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// c = cos(h)/cos(60deg-h) for h in tenths of a degree, rounded to frac_bits.
	// Used only to build the constant table at elaboration.
	function automatic logic signed [63:0] ratio_entry(input int unsigned h,
			input int unsigned frac_bits);
		logic [63:0]        x;
		logic [63:0]        ts;
		logic [63:0]        tc;
		logic [63:0]        ds;
		logic [63:0]        dc;
		logic [63:0]        mag;
		logic [63:0]        den_u;
		logic [63:0]        q;
		logic signed [63:0] s;
		logic signed [63:0] c;
		logic signed [63:0] den;
		logic               neg;
		int                 k;
		x  = udiv64(64'(h) * PI_Q30, 64'd1800);
		ts = x;
		tc = ONE_Q30;
		s  = $signed(x);
		c  = $signed(ONE_Q30);
		for (k = 1; k <= TAYLOR_TERMS; k++) begin
			ds = 64'((2 * k) * (2 * k + 1));
			dc = 64'((2 * k - 1) * (2 * k));
			ts = (ts * x) >> 30;
			ts = (ts * x) >> 30;
			ts = udiv64(ts, ds);
			tc = (tc * x) >> 30;
			tc = (tc * x) >> 30;
			tc = udiv64(tc, dc);
			if (k % 2 == 1) begin
				s = s - $signed(ts);
				c = c - $signed(tc);
			end else begin
				s = s + $signed(ts);
				c = c + $signed(tc);
			end
		end
		if (s < 0) begin
			s = '0;
		end
		den = c + $signed(($unsigned(s) * SQRT3_Q30) >> 30);
		neg = c < 0;
		mag = neg ? $unsigned(-c) : $unsigned(c);
		if (den < 1) begin
			den = 64'sd1;
		end
		den_u = $unsigned(den);
		q = udiv64((mag << (frac_bits + 1)) + (den_u >> 1), den_u);
		return neg ? -$signed(q) : $signed(q);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/hsi2rgb_front.sv =====
`default_nettype none

// Hue reduction and sector split, two stages ahead of the queue.
module hsi2rgb_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [hsi2rgb_pkg::HUE_W-1:0]       hue,
	input  wire logic [hsi2rgb_pkg::CH_W-1:0]        sat,
	input  wire logic [hsi2rgb_pkg::CH_W-1:0]        inten,
	input  wire logic                                full,
	output logic                                     push,
	output hsi2rgb_pkg::item_t                       item
);

	localparam int ProdW = hsi2rgb_pkg::HUE_W + hsi2rgb_pkg::HUE_RECIP_W;
	localparam int QW    = ProdW - hsi2rgb_pkg::HUE_RECIP_SHIFT;
	localparam int RawW  = 13;   // remainder before correction, < 7200
	localparam int RedW  = 12;   // reduced hue, < 3600

	logic                             v_s1;
	logic                             v_s2;
	logic [ProdW-1:0]                 prod_s1;
	logic [hsi2rgb_pkg::HUE_W-1:0]    hue_s1;
	logic [hsi2rgb_pkg::CH_W-1:0]     sat_s1;
	logic [hsi2rgb_pkg::CH_W-1:0]     inten_s1;
	logic [RedW-1:0]                  hred_s2;
	logic [hsi2rgb_pkg::CH_W-1:0]     sat_s2;
	logic [hsi2rgb_pkg::CH_W-1:0]     inten_s2;
	logic                             en;
	logic [QW-1:0]                    q_est;
	logic [RawW-1:0]                  r_raw;
	logic [RedW-1:0]                  r_red;

	assign en       = !(v_s2 && full);
	assign in_ready = en;
	assign push     = v_s2 && !full;

	always_comb begin
		q_est = prod_s1[ProdW-1:hsi2rgb_pkg::HUE_RECIP_SHIFT];
		r_raw = RawW'(hue_s1) - RawW'(q_est * hsi2rgb_pkg::HUE_PERIOD);
		if (r_raw >= RawW'(hsi2rgb_pkg::HUE_PERIOD)) begin
			r_red = RedW'(r_raw - RawW'(hsi2rgb_pkg::HUE_PERIOD));
		end else begin
			r_red = RedW'(r_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= ProdW'(hue) * ProdW'(hsi2rgb_pkg::HUE_RECIP);
			hue_s1   <= hue;
			sat_s1   <= sat;
			inten_s1 <= inten;
			hred_s2  <= r_red;
			sat_s2   <= sat_s1;
			inten_s2 <= inten_s1;
		end
	end

	// split the reduced hue into sector and offset
	always_comb begin
		item.sat   = sat_s2;
		item.inten = inten_s2;
		priority if (hred_s2 >= RedW'(2 * hsi2rgb_pkg::SECTOR_SPAN)) begin
			item.sector = hsi2rgb_pkg::SEC_BLUE_LEAD;
			item.h = hsi2rgb_pkg::H_W'(hred_s2 - RedW'(2 * hsi2rgb_pkg::SECTOR_SPAN));
		end else if (hred_s2 >= RedW'(hsi2rgb_pkg::SECTOR_SPAN)) begin
			item.sector = hsi2rgb_pkg::SEC_GREEN_LEAD;
			item.h = hsi2rgb_pkg::H_W'(hred_s2 - RedW'(hsi2rgb_pkg::SECTOR_SPAN));
		end else begin
			item.sector = hsi2rgb_pkg::SEC_RED_LEAD;
			item.h = hsi2rgb_pkg::H_W'(hred_s2);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hsi2rgb_queue.sv =====
`default_nettype none

// Small FIFO between the front and the back.
module hsi2rgb_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire hsi2rgb_pkg::item_t   push_item,
	output logic                      full,
	input  wire logic                 pop,
	output hsi2rgb_pkg::item_t        pop_item,
	output logic                      empty
);

	localparam int CntW = hsi2rgb_pkg::QUEUE_PTR_W + 1;

	hsi2rgb_pkg::item_t                      mem_q [hsi2rgb_pkg::QUEUE_DEPTH];
	logic [hsi2rgb_pkg::QUEUE_PTR_W-1:0]     wr_ptr_q;
	logic [hsi2rgb_pkg::QUEUE_PTR_W-1:0]     rd_ptr_q;
	logic [CntW-1:0]                         count_q;

	assign full     = count_q == CntW'(hsi2rgb_pkg::QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hsi2rgb_back.sv =====
`default_nettype none

// Ratio lookup and channel arithmetic, five stages, stalls as one.
module hsi2rgb_back #(
	parameter int RATIO_FRACTION_BITS = 14
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire hsi2rgb_pkg::item_t              item,
	input  wire logic                            empty,
	output logic                                 pop,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [hsi2rgb_pkg::CH_W-1:0]         red,
	output logic [hsi2rgb_pkg::CH_W-1:0]         green,
	output logic [hsi2rgb_pkg::CH_W-1:0]         blue
);

	localparam int F     = RATIO_FRACTION_BITS;
	localparam int CqW   = F + 3;        // ratio spans -1.0 .. 2.0
	localparam int FW    = F + 12;       // factor, signed
	localparam int NW    = FW + 9;       // intensity * factor, signed
	localparam int CW    = hsi2rgb_pkg::CH_W;
	localparam int VW    = hsi2rgb_pkg::DIV_IN_W;
	localparam int PW    = hsi2rgb_pkg::DIV_PROD_W;
	localparam int QeW   = PW - hsi2rgb_pkg::DIV_RECIP_SHIFT;
	localparam logic signed [FW-1:0] BaseP = FW'(255) <<< F;

	typedef logic signed [CqW-1:0] rom_t [hsi2rgb_pkg::SECTOR_SPAN];

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < hsi2rgb_pkg::SECTOR_SPAN; i++) begin
			r[i] = CqW'(hsi2rgb_pkg::ratio_entry(i, F));
		end
		return r;
	endfunction

	localparam rom_t RatioRom = build_rom();

	// finish v / 765 with one correction, clamp, zero for a nonpositive numerator
	function automatic logic [CW-1:0] finish(input logic nz, input logic [VW-1:0] v,
			input logic [PW-1:0] prod);
		logic [QeW-1:0] qe;
		logic [VW-1:0]  r;
		qe = prod[PW-1:hsi2rgb_pkg::DIV_RECIP_SHIFT];
		r  = v - VW'(qe * hsi2rgb_pkg::CHAN_DIV);
		if (r >= VW'(hsi2rgb_pkg::CHAN_DIV)) begin
			qe = qe + 1'b1;
		end
		if (!nz) begin
			return '0;
		end else if (qe > QeW'(255)) begin
			return '1;
		end
		return qe[CW-1:0];
	endfunction

	logic                     en;
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	hsi2rgb_pkg::sector_t     sec_s1, sec_s2, sec_s3, sec_s4;
	logic signed [CqW-1:0]    cq_s1;
	logic [CW-1:0]            sat_s1, sat_s2;
	logic [CW-1:0]            inten_s1, inten_s2;
	logic signed [FW-1:0]     scq_s2;
	logic signed [NW-1:0]     nump_s3, numq_s3;
	logic [2*CW-1:0]          numt_s3;
	logic                     nzp_s4, nzq_s4, nzt_s4;
	logic [VW-1:0]            vp_s4, vq_s4, vt_s4;
	logic [PW-1:0]            prodp_s4, prodq_s4, prodt_s4;
	logic [CW-1:0]            red_s5, green_s5, blue_s5;

	logic signed [FW-1:0]     fp, fq;
	logic                     nzp, nzq, nzt;
	logic [VW-1:0]            vp, vq, vt;
	logic [CW-1:0]            chp, chq, cht;

	assign en        = !v_s5 || out_ready;
	assign pop       = en && !empty;
	assign out_valid = v_s5;
	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;

	always_comb begin
		fp = BaseP + scq_s2;
		fq = ($signed(FW'(10'd255 + 10'(sat_s2))) <<< F) - scq_s2;
	end

	always_comb begin
		nzp = nump_s3 > 0;
		nzq = numq_s3 > 0;
		nzt = numt_s3 != '0;
		vp  = nzp ? VW'(nump_s3 >>> F) : '0;
		vq  = nzq ? VW'(numq_s3 >>> F) : '0;
		vt  = VW'(numt_s3);
	end

	always_comb begin
		chp = finish(nzp_s4, vp_s4, prodp_s4);
		chq = finish(nzq_s4, vq_s4, prodq_s4);
		cht = finish(nzt_s4, vt_s4, prodt_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= !empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// table read, registered
			cq_s1    <= RatioRom[item.h];
			sec_s1   <= item.sector;
			sat_s1   <= item.sat;
			inten_s1 <= item.inten;
			// S * c
			scq_s2   <= $signed({1'b0, sat_s1}) * cq_s1;
			sec_s2   <= sec_s1;
			sat_s2   <= sat_s1;
			inten_s2 <= inten_s1;
			// I * factor
			nump_s3  <= $signed({1'b0, inten_s2}) * fp;
			numq_s3  <= $signed({1'b0, inten_s2}) * fq;
			numt_s3  <= inten_s2 * (CW'(255) - sat_s2);
			sec_s3   <= sec_s2;
			// reciprocal multiply for / 765
			nzp_s4   <= nzp;
			nzq_s4   <= nzq;
			nzt_s4   <= nzt;
			vp_s4    <= vp;
			vq_s4    <= vq;
			vt_s4    <= vt;
			prodp_s4 <= PW'(vp) * PW'(hsi2rgb_pkg::DIV_RECIP);
			prodq_s4 <= PW'(vq) * PW'(hsi2rgb_pkg::DIV_RECIP);
			prodt_s4 <= PW'(vt) * PW'(hsi2rgb_pkg::DIV_RECIP);
			sec_s4   <= sec_s3;
			// route primary/secondary/tertiary to R, G, B
			unique case (sec_s4)
				hsi2rgb_pkg::SEC_RED_LEAD: begin
					red_s5   <= chp;
					green_s5 <= chq;
					blue_s5  <= cht;
				end
				hsi2rgb_pkg::SEC_GREEN_LEAD: begin
					green_s5 <= chp;
					blue_s5  <= chq;
					red_s5   <= cht;
				end
				default: begin
					blue_s5  <= chp;
					red_s5   <= chq;
					green_s5 <= cht;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hsi_to_rgb_converter.sv =====
// Channel   Dir  Width  Contents (low bit first)
// s_axis    in   32     hue[15:0], saturation[23:16], intensity[31:24]
// m_axis    out  24     red[7:0], green[15:8], blue[23:16]
//
// One pixel per clock sustained while m_axis_tready stays high; a pixel passes the front's
// 2 stages into the queue, then the back's 5 stages, the first loading from the queue.
// The ratio table is read in the first back stage.
// arst_n clears all valid bits and queue pointers; payload registers are not reset.
// A stall on m_axis freezes the back stages; the 4-entry queue then fills before
// s_axis_tready drops, so the front keeps taking pixels until the queue is full and a pixel waits in its second stage.
// No clearing pass: the ratio table is a constant ROM.
`default_nettype none

module hsi_to_rgb_converter #(
	parameter int RATIO_FRACTION_BITS = 14   // ratio fraction bits, 8..16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input pixel stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // hue[15:0], saturation[23:16], intensity[31:24]
	// output pixel stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

	hsi2rgb_pkg::item_t push_item;
	hsi2rgb_pkg::item_t pop_item;
	logic               push;
	logic               pop;
	logic               full;
	logic               empty;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;

	// Front: hue mod 3600 by reciprocal multiply, then sector and in-sector offset.
	hsi2rgb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.hue      (s_axis_tdata[15:0]),
		.sat      (s_axis_tdata[23:16]),
		.inten    (s_axis_tdata[31:24]),
		.full     (full),
		.push     (push),
		.item     (push_item)
	);

	// Decoupling queue; each side stalls on its own.
	hsi2rgb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	// Back: ratio ROM, S*c, I*factor, / 765 by reciprocal, clamp, channel routing.
	// Its last stage is the output register.
	hsi2rgb_back #(
		.RATIO_FRACTION_BITS (RATIO_FRACTION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (pop_item),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	assign m_axis_tdata = {blue, green, red};

endmodule

`default_nettype wire

// ===== rtl/hsi2rgb_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

// Port-level checks on the converter.
module hsi2rgb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [31:0] s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata
);

	// front 2 + queue 4 + back 5
	localparam logic [3:0] MaxInFlight = 4'd11;

	logic [3:0] inflight_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			unique case ({in_xfer, out_xfer})
				2'b10:   inflight_q <= inflight_q + 1'b1;
				2'b01:   inflight_q <= inflight_q - 1'b1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	`ASSERT_CLK(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed or dropped")
	`ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !m_axis_tvalid, "result shown during reset")
	`ASSERT_CLK(a_no_phantom, clk, arst_n, m_axis_tvalid |-> inflight_q != 4'd0, "result without a pending pixel")
	`ASSERT_CLK(a_bounded, clk, arst_n, inflight_q <= MaxInFlight, "more pixels in flight than storage")
	`ASSERT_CLK(a_tdata_known, clk, arst_n, in_xfer |-> !$isunknown(s_axis_tdata), "unknown input transfer data")

endmodule

bind hsi_to_rgb_converter hsi2rgb_checker u_hsi2rgb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
